// ----- design/rmq_pkg.sv -----
// rmq_pkg: types and constants shared by the rotation matrix to quaternion block
// no dependencies
package rmq_pkg;

  localparam int RAD_W     = 17;
  localparam int S_W       = 17;
  localparam int DMAG_W    = 17;
  localparam int REM_W     = 18;
  localparam int Q_W       = 23;
  localparam int NLO_W     = 23;
  localparam int SQ_STEPS  = 17;
  localparam int DIV_STEPS = 23;
  localparam int LANES     = 3;

  localparam logic signed [18:0] ONE_Q14 = 19'sd16384;
  localparam logic [Q_W-1:0] COMP_MAX = 23'd16384;

  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_COL0  = 2'd1;
  localparam logic [1:0] BR_COL1  = 2'd2;
  localparam logic [1:0] BR_COL2  = 2'd3;

  typedef struct packed {
    logic signed [15:0] r0c0;
    logic signed [15:0] r1c0;
    logic signed [15:0] r2c0;
    logic signed [15:0] r0c1;
    logic signed [15:0] r1c1;
    logic signed [15:0] r2c1;
    logic signed [15:0] r0c2;
    logic signed [15:0] r1c2;
    logic signed [15:0] r2c2;
  } rmq_in_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic [1:0]         branch_taken;
    logic               saturated;
  } rmq_out_t;

  typedef struct packed {
    logic              neg;
    logic [DMAG_W-1:0] mag;
  } rmq_term_t;

  typedef struct packed {
    logic [1:0]                 branch;
    rmq_term_t [LANES-1:0]      term;
  } rmq_sq_sb_t;

  typedef struct packed {
    logic [1:0]       branch;
    logic [S_W-1:0]   s;
    logic [LANES-1:0] neg;
  } rmq_dv_sb_t;

endpackage

// ----- design/rmq_front.sv -----
// rmq_front: trace test, branch pick, radicand and off-diagonal terms, one register stage
// depends on rmq_pkg
module rmq_front import rmq_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  rmq_in_t       data_i,
  input  logic [14:0]   thresh_i,
  output logic          valid_o,
  output logic [RAD_W-1:0] rad_o,
  output rmq_sq_sb_t    sb_o
);

  function automatic rmq_term_t abs_term(input logic signed [18:0] d);
    rmq_term_t r;
    logic [18:0] m;
    m = d[18] ? 19'(-d) : d;
    r.neg = d[18];
    r.mag = m[DMAG_W-1:0];
    return r;
  endfunction

  logic signed [18:0] a00, a10, a20, a01, a11, a21, a02, a12, a22;
  logic signed [18:0] t, rad_sel;
  logic signed [18:0] dx, dy, dz, s01, s02, s12;
  logic               trace_ok, c0, c1;
  logic [1:0]         br;
  logic [RAD_W-1:0]   rad;
  rmq_sq_sb_t         sb;
  logic               v_q;
  logic [RAD_W-1:0]   rad_q;
  rmq_sq_sb_t         sb_q;

  assign a00 = 19'(data_i.r0c0);
  assign a10 = 19'(data_i.r1c0);
  assign a20 = 19'(data_i.r2c0);
  assign a01 = 19'(data_i.r0c1);
  assign a11 = 19'(data_i.r1c1);
  assign a21 = 19'(data_i.r2c1);
  assign a02 = 19'(data_i.r0c2);
  assign a12 = 19'(data_i.r1c2);
  assign a22 = 19'(data_i.r2c2);

  assign t        = ONE_Q14 + a00 + a11 + a22;
  assign trace_ok = t > $signed({4'b0000, thresh_i});
  assign c0       = (a00 > a11) && (a00 > a22);
  assign c1       = a11 > a22;

  assign dx  = a12 - a21;
  assign dy  = a20 - a02;
  assign dz  = a01 - a10;
  assign s01 = a01 + a10;
  assign s02 = a20 + a02;
  assign s12 = a12 + a21;

  always_comb begin
    priority if (trace_ok) begin
      br      = BR_TRACE;
      rad_sel = t;
    end else if (c0) begin
      br      = BR_COL0;
      rad_sel = ONE_Q14 + a00 - a11 - a22;
    end else if (c1) begin
      br      = BR_COL1;
      rad_sel = ONE_Q14 + a11 - a00 - a22;
    end else begin
      br      = BR_COL2;
      rad_sel = ONE_Q14 + a22 - a00 - a11;
    end
  end

  assign rad = (rad_sel < 19'sd1) ? 17'd1 : rad_sel[RAD_W-1:0];

  // lanes hold the three quotient components in w, x, y, z order
  always_comb begin
    sb.branch = br;
    unique case (br)
      BR_TRACE: begin
        sb.term[0] = abs_term(dx);
        sb.term[1] = abs_term(dy);
        sb.term[2] = abs_term(dz);
      end
      BR_COL0: begin
        sb.term[0] = abs_term(dx);
        sb.term[1] = abs_term(s01);
        sb.term[2] = abs_term(s02);
      end
      BR_COL1: begin
        sb.term[0] = abs_term(dy);
        sb.term[1] = abs_term(s01);
        sb.term[2] = abs_term(s12);
      end
      BR_COL2: begin
        sb.term[0] = abs_term(dz);
        sb.term[1] = abs_term(s02);
        sb.term[2] = abs_term(s12);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q <= rad;
      sb_q  <= sb;
    end
  end

  assign valid_o = v_q;
  assign rad_o   = rad_q;
  assign sb_o    = sb_q;

endmodule

// ----- design/rmq_sqrt.sv -----
// rmq_sqrt: pipelined integer square root of radicand * 65536, one root bit per stage
// depends on rmq_pkg
module rmq_sqrt import rmq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [RAD_W-1:0] rad_i,
  input  rmq_sq_sb_t       sb_i,
  output logic             valid_o,
  output logic [S_W-1:0]   s_o,
  output rmq_sq_sb_t       sb_o
);

  logic             v_q      [SQ_STEPS];
  logic [RAD_W-1:0] rad_q    [SQ_STEPS];
  logic [REM_W-1:0] rem_q    [SQ_STEPS];
  logic [S_W-1:0]   root_q   [SQ_STEPS];
  rmq_sq_sb_t       sb_q     [SQ_STEPS];
  logic             cur_v    [SQ_STEPS];
  logic [RAD_W-1:0] cur_rad  [SQ_STEPS];
  logic [REM_W-1:0] cur_rem  [SQ_STEPS];
  logic [S_W-1:0]   cur_root [SQ_STEPS];
  rmq_sq_sb_t       cur_sb   [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    localparam int P = SQ_STEPS - 1 - k;
    logic [1:0]  pair;
    logic [19:0] rr, trial, diff;
    logic [17:0] rad18;
    logic        ge;

    if (k == 0) begin : g_in
      assign cur_v[k]    = valid_i;
      assign cur_rad[k]  = rad_i;
      assign cur_rem[k]  = '0;
      assign cur_root[k] = '0;
      assign cur_sb[k]   = sb_i;
    end else begin : g_prev
      assign cur_v[k]    = v_q[k-1];
      assign cur_rad[k]  = rad_q[k-1];
      assign cur_rem[k]  = rem_q[k-1];
      assign cur_root[k] = root_q[k-1];
      assign cur_sb[k]   = sb_q[k-1];
    end

    assign rad18 = {1'b0, cur_rad[k]};
    // the low 16 bits of the shifted radicand are zero
    if (P >= 8) begin : g_hi
      assign pair = rad18[2*(P-8)+1 -: 2];
    end else begin : g_lo
      assign pair = 2'b00;
    end

    assign rr    = {cur_rem[k], pair};
    assign trial = {1'b0, cur_root[k], 2'b01};
    assign ge    = rr >= trial;
    assign diff  = rr - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= cur_v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= cur_rad[k];
        rem_q[k]  <= ge ? diff[REM_W-1:0] : rr[REM_W-1:0];
        root_q[k] <= {cur_root[k][S_W-2:0], ge};
        sb_q[k]   <= cur_sb[k];
      end
    end
  end

  assign valid_o = v_q[SQ_STEPS-1];
  assign s_o     = root_q[SQ_STEPS-1];
  assign sb_o    = sb_q[SQ_STEPS-1];

endmodule

// ----- design/rmq_div.sv -----
// rmq_div: three-lane pipelined restoring divider, round(|d| * 16384 / s), one bit per stage
// depends on rmq_pkg
module rmq_div import rmq_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [S_W-1:0]            s_i,
  input  rmq_sq_sb_t                sb_i,
  output logic                      valid_o,
  output logic [LANES-1:0][Q_W-1:0] q_o,
  output rmq_dv_sb_t                sb_o
);

  logic                          v_q     [DIV_STEPS];
  logic [LANES-1:0][REM_W-1:0]   rem_q   [DIV_STEPS];
  logic [LANES-1:0][Q_W-1:0]     quo_q   [DIV_STEPS];
  logic [LANES-1:0][NLO_W-1:0]   nlo_q   [DIV_STEPS];
  rmq_dv_sb_t                    sb_q    [DIV_STEPS];
  logic                          cur_v   [DIV_STEPS];
  logic [LANES-1:0][REM_W-1:0]   cur_rem [DIV_STEPS];
  logic [LANES-1:0][Q_W-1:0]     cur_quo [DIV_STEPS];
  logic [LANES-1:0][NLO_W-1:0]   cur_nlo [DIV_STEPS];
  rmq_dv_sb_t                    cur_sb  [DIV_STEPS];
  logic [LANES-1:0][31:0]        num;
  rmq_dv_sb_t                    in_sb;

  // numerator 2 * |d| * 16384 + s, divisor 2 * s
  for (genvar l = 0; l < LANES; l++) begin : g_num
    assign num[l]       = {sb_i.term[l].mag, 15'b0} + {15'b0, s_i};
    assign in_sb.neg[l] = sb_i.term[l].neg;
  end
  assign in_sb.branch = sb_i.branch;
  assign in_sb.s      = s_i;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [REM_W:0] dvs;

    if (k == 0) begin : g_in
      assign cur_v[k]  = valid_i;
      assign cur_sb[k] = in_sb;
      for (genvar l = 0; l < LANES; l++) begin : g_lane_in
        assign cur_rem[k][l] = {9'b0, num[l][31:23]};
        assign cur_quo[k][l] = '0;
        assign cur_nlo[k][l] = num[l][NLO_W-1:0];
      end
    end else begin : g_prev
      assign cur_v[k]   = v_q[k-1];
      assign cur_sb[k]  = sb_q[k-1];
      assign cur_rem[k] = rem_q[k-1];
      assign cur_quo[k] = quo_q[k-1];
      assign cur_nlo[k] = nlo_q[k-1];
    end

    assign dvs = {1'b0, cur_sb[k].s, 1'b0};

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [REM_W:0] rr, diff;
      logic           ge;
      assign rr   = {cur_rem[k][l], cur_nlo[k][l][NLO_W-1-k]};
      assign ge   = rr >= dvs;
      assign diff = rr - dvs;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k][l] <= ge ? diff[REM_W-1:0] : rr[REM_W-1:0];
          quo_q[k][l] <= {cur_quo[k][l][Q_W-2:0], ge};
          nlo_q[k][l] <= cur_nlo[k][l];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= cur_v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sb_q[k] <= cur_sb[k];
      end
    end
  end

  assign valid_o = v_q[DIV_STEPS-1];
  assign q_o     = quo_q[DIV_STEPS-1];
  assign sb_o    = sb_q[DIV_STEPS-1];

endmodule

// ----- design/rotation_matrix_to_quaternion.sv -----
// rotation_matrix_to_quaternion: top level, front stage, square root, divider, clamp, output skid
// one item per cycle sustained while the skid entry is empty
// the depth comes mostly from the 17-stage square root and the 23-stage divider, one bit per stage
// one output register plus one skid entry; the pipeline freezes only while the skid is full
// rst_ni clears all valid bits and the threshold register to 0; no clearing pass
// depends on rmq_pkg, rmq_front, rmq_sqrt, rmq_div
module rotation_matrix_to_quaternion import rmq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  rmq_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rmq_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [14:0] cfg_data_i
);

  function automatic logic [16:0] clamp_comp(input logic neg, input logic [Q_W-1:0] mag);
    logic [Q_W-1:0] m;
    logic           sat;
    sat = mag > COMP_MAX;
    m   = sat ? COMP_MAX : mag;
    return {sat, neg ? 16'(-m) : m[15:0]};
  endfunction

  logic                      en;
  logic [14:0]               thresh_q;
  logic                      fr_v, sq_v, dv_v;
  logic [RAD_W-1:0]          fr_rad;
  rmq_sq_sb_t                fr_sb, sq_sb;
  logic [S_W-1:0]            sq_s;
  logic [LANES-1:0][Q_W-1:0] dv_q;
  rmq_dv_sb_t                dv_sb;
  logic [17:0]               s_p2;
  logic [Q_W-1:0]            qtr;
  logic [16:0]               c_qtr, c_l0, c_l1, c_l2;
  rmq_out_t                  res;
  logic                      out_v_q, sk_v_q;
  rmq_out_t                  out_q, sk_q;

  assign en          = !sk_v_q;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= '0;
    end else if (cfg_valid_i) begin
      thresh_q <= cfg_data_i;
    end
  end

  rmq_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .data_i   (in_data_i),
    .thresh_i (thresh_q),
    .valid_o  (fr_v),
    .rad_o    (fr_rad),
    .sb_o     (fr_sb)
  );

  rmq_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_v),
    .rad_i   (fr_rad),
    .sb_i    (fr_sb),
    .valid_o (sq_v),
    .s_o     (sq_s),
    .sb_o    (sq_sb)
  );

  rmq_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_v),
    .s_i     (sq_s),
    .sb_i    (sq_sb),
    .valid_o (dv_v),
    .q_o     (dv_q),
    .sb_o    (dv_sb)
  );

  // s / 4 rounded half up
  assign s_p2  = {1'b0, dv_sb.s} + 18'd2;
  assign qtr   = {7'b0, s_p2[17:2]};
  assign c_qtr = clamp_comp(1'b0, qtr);
  assign c_l0  = clamp_comp(dv_sb.neg[0], dv_q[0]);
  assign c_l1  = clamp_comp(dv_sb.neg[1], dv_q[1]);
  assign c_l2  = clamp_comp(dv_sb.neg[2], dv_q[2]);

  always_comb begin
    res.branch_taken = dv_sb.branch;
    res.saturated    = c_qtr[16] | c_l0[16] | c_l1[16] | c_l2[16];
    unique case (dv_sb.branch)
      BR_TRACE: begin
        res.quat_w = c_qtr[15:0];
        res.quat_x = c_l0[15:0];
        res.quat_y = c_l1[15:0];
        res.quat_z = c_l2[15:0];
      end
      BR_COL0: begin
        res.quat_w = c_l0[15:0];
        res.quat_x = c_qtr[15:0];
        res.quat_y = c_l1[15:0];
        res.quat_z = c_l2[15:0];
      end
      BR_COL1: begin
        res.quat_w = c_l0[15:0];
        res.quat_x = c_l1[15:0];
        res.quat_y = c_qtr[15:0];
        res.quat_z = c_l2[15:0];
      end
      BR_COL2: begin
        res.quat_w = c_l0[15:0];
        res.quat_x = c_l1[15:0];
        res.quat_y = c_l2[15:0];
        res.quat_z = c_qtr[15:0];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else if (out_ready_i || !out_v_q) begin
      if (sk_v_q) begin
        out_v_q <= 1'b1;
        sk_v_q  <= 1'b0;
      end else begin
        out_v_q <= dv_v;
      end
    end else if (dv_v && en) begin
      sk_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready_i || !out_v_q) begin
      out_q <= sk_v_q ? sk_q : res;
    end else if (en) begin
      sk_q <= res;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_skid_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_v_q |-> out_v_q)
    else $error("skid item held without an output item");

  a_skid_fill_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sk_v_q) |-> $past(out_v_q && !out_ready_i))
    else $error("skid filled while output was free");

  a_trace_w_nonneg : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && (out_q.branch_taken == BR_TRACE) |-> !out_q.quat_w[15])
    else $error("trace branch gave negative w");
`endif

endmodule

// ----- test/tb_rotation_matrix_to_quaternion.sv -----
// tb_rotation_matrix_to_quaternion: checks the matrix to quaternion block against a
// behavioral predictor, with directed and random matrices, random stalls and thresholds
// depends on rmq_pkg and rotation_matrix_to_quaternion
module tb_rotation_matrix_to_quaternion;
  import rmq_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  rmq_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  rmq_out_t    out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [14:0] cfg_data_i = '0;

  rotation_matrix_to_quaternion i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  localparam int LATENCY = 42;
  localparam longint CYCLE_LIMIT = 400000;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rmq_out_t    quat_queue[$];
  logic [14:0] threshold = '0;
  int          errors = 0;
  int          checked = 0;
  longint      cycles = 0;
  int          idle_pct = 35;
  int          hold_cycles = 0;
  int          branch_seen[4] = '{0, 0, 0, 0};

  function automatic longint root_floor(longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 40;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint scale_of(longint rad);
    if (rad < 1) rad = 1;
    return root_floor(rad <<< 16);
  endfunction

  function automatic longint div_round(longint d, longint s);
    longint num, mag, q;
    num = d * 16384;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + s) / (2 * s);
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic signed [15:0] clamp_comp(longint v, ref logic sat);
    if (v > 16384) begin
      sat = 1'b1;
      return 16'sd16384;
    end
    if (v < -16384) begin
      sat = 1'b1;
      return -16'sd16384;
    end
    return v[15:0];
  endfunction

  function automatic rmq_out_t predict_quat(rmq_in_t m);
    longint a00, a10, a20, a01, a11, a21, a02, a12, a22, t, s, w, x, y, z;
    logic [1:0] br;
    logic sat;
    rmq_out_t q;
    a00 = m.r0c0; a10 = m.r1c0; a20 = m.r2c0;
    a01 = m.r0c1; a11 = m.r1c1; a21 = m.r2c1;
    a02 = m.r0c2; a12 = m.r1c2; a22 = m.r2c2;
    sat = 1'b0;
    t = 16384 + a00 + a11 + a22;
    if (t > longint'(threshold)) begin
      br = BR_TRACE;
      s = scale_of(t);
      x = div_round(a12 - a21, s);
      y = div_round(a20 - a02, s);
      z = div_round(a01 - a10, s);
      w = (s + 2) >>> 2;
    end else if (a00 > a11 && a00 > a22) begin
      br = BR_COL0;
      s = scale_of(16384 + a00 - a11 - a22);
      x = (s + 2) >>> 2;
      y = div_round(a01 + a10, s);
      z = div_round(a20 + a02, s);
      w = div_round(a12 - a21, s);
    end else if (a11 > a22) begin
      br = BR_COL1;
      s = scale_of(16384 + a11 - a00 - a22);
      x = div_round(a01 + a10, s);
      y = (s + 2) >>> 2;
      z = div_round(a12 + a21, s);
      w = div_round(a20 - a02, s);
    end else begin
      br = BR_COL2;
      s = scale_of(16384 + a22 - a00 - a11);
      x = div_round(a20 + a02, s);
      y = div_round(a12 + a21, s);
      z = (s + 2) >>> 2;
      w = div_round(a01 - a10, s);
    end
    q.quat_w = clamp_comp(w, sat);
    q.quat_x = clamp_comp(x, sat);
    q.quat_y = clamp_comp(y, sat);
    q.quat_z = clamp_comp(z, sat);
    q.branch_taken = br;
    q.saturated = sat;
    return q;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    rmq_out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (quat_queue.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        e = quat_queue.pop_front();
        checked++;
        branch_seen[e.branch_taken]++;
        if (out_data_o.quat_w !== e.quat_w) report_mismatch("quat_w", out_data_o.quat_w, e.quat_w);
        if (out_data_o.quat_x !== e.quat_x) report_mismatch("quat_x", out_data_o.quat_x, e.quat_x);
        if (out_data_o.quat_y !== e.quat_y) report_mismatch("quat_y", out_data_o.quat_y, e.quat_y);
        if (out_data_o.quat_z !== e.quat_z) report_mismatch("quat_z", out_data_o.quat_z, e.quat_z);
        if (out_data_o.branch_taken !== e.branch_taken)
          report_mismatch("branch_taken", out_data_o.branch_taken, e.branch_taken);
        if (out_data_o.saturated !== e.saturated)
          report_mismatch("saturated", out_data_o.saturated, e.saturated);
      end
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= idle_pct);
    end
  end

  // valid drops for random idle gaps between items of a burst unless idle_pct is 0; each burst ends by dropping it
  task automatic send_matrix(rmq_in_t m);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_data_i <= m;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    quat_queue.push_back(predict_quat(m));
    @(negedge clk_i);
  endtask

  task automatic end_burst;
    in_valid_i <= 1'b0;
  endtask

  task automatic drain;
    while (quat_queue.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_threshold(logic [14:0] v);
    drain();
    cfg_data_i <= v;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    threshold = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic rmq_in_t make_matrix(int d0, int d1, int d2, int o);
    rmq_in_t m;
    m = '0;
    m.r0c0 = 16'(d0); m.r1c1 = 16'(d1); m.r2c2 = 16'(d2);
    m.r1c0 = 16'(o); m.r0c1 = 16'(-o); m.r2c1 = 16'(o); m.r1c2 = 16'(o / 2);
    m.r0c2 = 16'(-o); m.r2c0 = 16'(o / 3);
    return m;
  endfunction

  function automatic logic signed [15:0] rand_elem;
    case ($urandom_range(9))
      0: return 16'($urandom());
      1: return 16'sd16384;
      2: return -16'sd16384;
      default: return $signed(16'($urandom_range(32768))) - 16'sd16384;
    endcase
  endfunction

  // near-rotation matrix: signed permutation with small perturbation
  function automatic rmq_in_t rand_rotation;
    logic signed [15:0] e[9];
    int p[3];
    int k;
    rmq_in_t m;
    p = '{0, 1, 2};
    p.shuffle();
    for (k = 0; k < 9; k++) e[k] = $signed(16'($urandom_range(4000))) - 16'sd2000;
    for (k = 0; k < 3; k++)
      e[k * 3 + p[k]] = $urandom_range(1) ? 16'sd16384 - 16'($urandom_range(3000))
                                          : -16'sd16384 + 16'($urandom_range(3000));
    m.r0c0 = e[0]; m.r0c1 = e[1]; m.r0c2 = e[2];
    m.r1c0 = e[3]; m.r1c1 = e[4]; m.r1c2 = e[5];
    m.r2c0 = e[6]; m.r2c1 = e[7]; m.r2c2 = e[8];
    return m;
  endfunction

  task automatic test_directed;
    rmq_in_t m;
    send_matrix(make_matrix(16384, 16384, 16384, 0));
    send_matrix(make_matrix(16384, -16384, -16384, 0));
    send_matrix(make_matrix(-16384, 16384, -16384, 0));
    send_matrix(make_matrix(-16384, -16384, 16384, 0));
    send_matrix(make_matrix(-16384, -16384, -16384, 16384));
    send_matrix(make_matrix(-5000, -5000, -5000, 100));
    send_matrix(make_matrix(-8000, -8000, -9000, 300));
    send_matrix(make_matrix(-9000, -8000, -8000, 300));
    send_matrix(make_matrix(-16384, -16384, -16384, -16384));
    send_matrix(make_matrix(0, 0, -16384, 7));
    send_matrix(make_matrix(-32768, -32768, -32768, -32768));
    send_matrix(make_matrix(32767, -32768, 32767, 32767));
    send_matrix(make_matrix(-20000, 32767, 32767, -32768));
    m = '1;
    send_matrix(m);
    m = '0;
    send_matrix(m);
    for (int k = 0; k < 6; k++) send_matrix(rand_rotation());
    end_burst();
  endtask

  task automatic test_random(int n);
    rmq_in_t m;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 75) begin
        m = rand_rotation();
      end else begin
        m.r0c0 = rand_elem(); m.r1c0 = rand_elem(); m.r2c0 = rand_elem();
        m.r0c1 = rand_elem(); m.r1c1 = rand_elem(); m.r2c1 = rand_elem();
        m.r0c2 = rand_elem(); m.r1c2 = rand_elem(); m.r2c2 = rand_elem();
      end
      send_matrix(m);
    end
    end_burst();
  endtask

  task automatic test_no_idle(int n);
    idle_pct = 0;
    test_random(n);
    idle_pct = 35;
  endtask

  task automatic test_backpressure;
    @(negedge clk_i);
    hold_cycles = 150;
    test_random(120);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    write_threshold(15'd16384);
    test_directed();
    test_random(300);
    write_threshold(15'd0);
    test_random(300);
    write_threshold(15'd32767);
    test_random(200);
    write_threshold(15'd8192);
    test_no_idle(400);
    test_backpressure();
    write_threshold(15'($urandom_range(16384)));
    test_random(600);
    drain();
    $display("checked %0d quaternions under several thresholds, with stalls and a long hold",
             checked);
    $display("branches seen: trace %0d, col0 %0d, col1 %0d, col2 %0d",
             branch_seen[0], branch_seen[1], branch_seen[2], branch_seen[3]);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/rmq_pkg.sv
design/rmq_front.sv
design/rmq_sqrt.sv
design/rmq_div.sv
design/rotation_matrix_to_quaternion.sv
test/tb_rotation_matrix_to_quaternion.sv
